@@ hdl/tkcr_pkg.sv @@
// Shared types and constants for the TDI knee count and radiance block.
// Used by every module under tdi_knee_count_radiance; depends on nothing.
package tkcr_pkg;

	localparam int DET_N      = 4;
	localparam int OFF_W      = 10;
	localparam int GAIN_W     = 24;
	localparam int RAD_W      = 34;
	localparam int COUNT_W    = 18;
	localparam int KNEE_W     = 3;
	localparam int TERM_SHIFT = 6;
	localparam int Q_W        = 16;
	localparam int DIVD_W     = RAD_W + TERM_SHIFT;
	localparam int LANE_N     = DET_N - 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W     = 2;

	localparam logic [OFF_W-1:0]  SAT_FULL  = 10'd1023;
	localparam logic [Q_W-1:0]    Q_SAT     = 16'd65472;
	localparam logic [KNEE_W-1:0] KNEE_LAST = 3'd4;

	typedef struct packed {
		logic [DET_N-1:0][OFF_W-1:0]  sat;
		logic [DET_N-1:0][RAD_W-1:0]  rad;
		logic [DET_N-1:0][GAIN_W-1:0] gain;
	} tkcr_entry_t;

	typedef struct packed {
		logic valid;
		logic pop;
	} tkcr_qctl_t;

	typedef struct packed {
		logic [KNEE_W-1:0]  knee;
		logic               last;
		logic [RAD_W-1:0]   rad;
		logic [COUNT_W-1:0] ssum;
		logic [LANE_N-1:0]  act;
		logic [LANE_N-1:0]  zero;
	} tkcr_meta_t;

endpackage

@@ hdl/tkcr_front.sv @@
// Front end: accepts input transfers, forms saturation counts and radiances,
// and sorts the detectors by radiance. Depends on tkcr_pkg.
module tkcr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [135:0]         s_tdata,
	input  logic                 q_full,
	output logic                 q_wr,
	output tkcr_pkg::tkcr_entry_t q_wdata
);
	import tkcr_pkg::*;

	logic                  vld_s1;
	logic [OFF_W-1:0]      sat_s1  [DET_N];
	logic [GAIN_W-1:0]     gain_s1 [DET_N];
	logic [RAD_W-1:0]      rad_s1  [DET_N];
	logic [1:0]            rank    [DET_N];
	logic                  take;

	assign s_tready = !vld_s1 || !q_full;
	assign take     = s_tvalid && s_tready;
	assign q_wr     = vld_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < DET_N; i++) begin
				sat_s1[i]  <= SAT_FULL - s_tdata[i*OFF_W +: OFF_W];
				gain_s1[i] <= s_tdata[DET_N*OFF_W + i*GAIN_W +: GAIN_W];
				rad_s1[i]  <= RAD_W'(SAT_FULL - s_tdata[i*OFF_W +: OFF_W])
					* RAD_W'(s_tdata[DET_N*OFF_W + i*GAIN_W +: GAIN_W]);
			end
		end
	end

	always_comb begin
		q_wdata = '0;
		for (int i = 0; i < DET_N; i++) begin
			rank[i] = 2'd0;
			for (int j = 0; j < DET_N; j++) begin
				if (j != i && (rad_s1[j] < rad_s1[i] || (rad_s1[j] == rad_s1[i] && j < i)))
					rank[i] = rank[i] + 2'd1;
			end
		end
		for (int p = 0; p < DET_N; p++) begin
			for (int i = 0; i < DET_N; i++) begin
				if (rank[i] == 2'(p)) begin
					q_wdata.sat[p]  = sat_s1[i];
					q_wdata.rad[p]  = rad_s1[i];
					q_wdata.gain[p] = gain_s1[i];
				end
			end
		end
	end

endmodule

@@ hdl/tkcr_queue.sv @@
// Short register queue of sorted items between front and back end.
// Depends on tkcr_pkg.
module tkcr_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr,
	input  tkcr_pkg::tkcr_entry_t wdata,
	output logic                  full,
	output tkcr_pkg::tkcr_qctl_t  ctl_o,
	input  logic                  pop,
	output tkcr_pkg::tkcr_entry_t rdata
);
	import tkcr_pkg::*;

	tkcr_entry_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]    wptr_q, rptr_q;
	logic [QPTR_W:0]      cnt_q;

	assign full        = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign ctl_o.valid = (cnt_q != '0);
	assign ctl_o.pop   = pop;
	assign rdata       = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			if (wr && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wptr_q] <= wdata;
	end

endmodule

@@ hdl/tkcr_div_lane.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on tkcr_pkg.
module tkcr_div_lane (
	input  logic                        clk,
	input  logic                        en,
	input  logic [tkcr_pkg::DIVD_W-1:0] dividend,
	input  logic [tkcr_pkg::GAIN_W-1:0] divisor,
	output logic [tkcr_pkg::Q_W-1:0]    quotient
);
	import tkcr_pkg::*;

	logic [DIVD_W-1:0] rem_s [Q_W];
	logic [GAIN_W-1:0] dvs_s [Q_W];
	logic [Q_W-1:0]    q_s   [Q_W];

	for (genvar g = 0; g < Q_W; g++) begin : g_stage
		logic [DIVD_W-1:0] rin, sh;
		logic [GAIN_W-1:0] din;
		logic [Q_W-1:0]    qin;
		if (g == 0) begin : g_first
			assign rin = dividend;
			assign din = divisor;
			assign qin = '0;
		end else begin : g_next
			assign rin = rem_s[g-1];
			assign din = dvs_s[g-1];
			assign qin = q_s[g-1];
		end
		assign sh = {{(DIVD_W-GAIN_W){1'b0}}, din} << (Q_W-1-g);
		always_ff @(posedge clk) begin
			if (en) begin
				dvs_s[g] <= din;
				if (rin >= sh) begin
					rem_s[g] <= rin - sh;
					q_s[g]   <= {qin[Q_W-2:0], 1'b1};
				end else begin
					rem_s[g] <= rin;
					q_s[g]   <= {qin[Q_W-2:0], 1'b0};
				end
			end
		end
	end

	assign quotient = q_s[Q_W-1];

endmodule

@@ hdl/tkcr_back.sv @@
// Back end: steps through the five knees of each queued item, runs the
// quotient lanes and sums the count terms. Depends on tkcr_pkg, tkcr_div_lane.
module tkcr_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tkcr_pkg::tkcr_qctl_t  qctl,
	input  tkcr_pkg::tkcr_entry_t head,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [55:0]           m_tdata,
	output logic                  m_tlast
);
	import tkcr_pkg::*;

	logic                  en, issue;
	logic [KNEE_W-1:0]     knee_q;
	tkcr_meta_t            meta_in;
	tkcr_meta_t            meta_s [Q_W];
	logic                  vld_s  [Q_W];
	logic [DIVD_W-1:0]     divd;
	logic [Q_W-1:0]        quo    [LANE_N];
	logic [Q_W-1:0]        term   [LANE_N];
	logic [11:0]           satsum;
	logic                  out_vld_q;
	logic [KNEE_W-1:0]     out_knee_q;
	logic [COUNT_W-1:0]    out_count_q;
	logic [RAD_W-1:0]      out_rad_q;
	logic                  out_last_q;

	assign en    = !out_vld_q || m_tready;
	assign issue = en && qctl.valid;
	assign pop   = issue && (knee_q == KNEE_LAST);
	assign divd  = {meta_in.rad, {TERM_SHIFT{1'b0}}};

	always_comb begin
		satsum = '0;
		for (int m = 0; m < DET_N; m++) begin
			if (3'(m) < knee_q)
				satsum = satsum + 12'(head.sat[m]);
		end
		meta_in.knee = knee_q;
		meta_in.last = (knee_q == KNEE_LAST);
		meta_in.rad  = (knee_q == '0) ? '0 : head.rad[knee_q[1:0] - 2'd1];
		meta_in.ssum = {satsum, {TERM_SHIFT{1'b0}}};
		for (int j = 0; j < LANE_N; j++) begin
			meta_in.act[j]  = (knee_q != '0) && (3'(j + 1) >= knee_q);
			meta_in.zero[j] = (head.gain[j+1] == '0);
		end
	end

	for (genvar j = 0; j < LANE_N; j++) begin : g_lane
		tkcr_div_lane u_lane (
			.clk      (clk),
			.en       (en),
			.dividend (divd),
			.divisor  (head.gain[j+1]),
			.quotient (quo[j])
		);
		assign term[j] = !meta_s[Q_W-1].act[j] ? '0 :
			(meta_s[Q_W-1].zero[j] ? Q_SAT : quo[j]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knee_q    <= '0;
			out_vld_q <= 1'b0;
			for (int i = 0; i < Q_W; i++)
				vld_s[i] <= 1'b0;
		end else if (en) begin
			if (issue)
				knee_q <= (knee_q == KNEE_LAST) ? '0 : knee_q + 1'b1;
			vld_s[0] <= issue;
			for (int i = 1; i < Q_W; i++)
				vld_s[i] <= vld_s[i-1];
			out_vld_q <= vld_s[Q_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s[0] <= meta_in;
			for (int i = 1; i < Q_W; i++)
				meta_s[i] <= meta_s[i-1];
			out_knee_q  <= meta_s[Q_W-1].knee;
			out_last_q  <= meta_s[Q_W-1].last;
			out_rad_q   <= meta_s[Q_W-1].rad;
			out_count_q <= meta_s[Q_W-1].ssum + COUNT_W'(term[0])
				+ COUNT_W'(term[1]) + COUNT_W'(term[2]);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {1'b0, out_rad_q, out_count_q, out_knee_q};

	a_knee_range: assert property (@(posedge clk) disable iff (!arst_n)
		knee_q <= KNEE_LAST) else $error("knee counter out of range");
	a_last_knee: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[2:0] == KNEE_LAST)))
		else $error("tlast not on final knee");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qctl.valid) else $error("pop from empty queue");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(knee_q)) else $error("knee advanced while stalled");

endmodule

@@ hdl/tdi_knee_count_radiance.sv @@
// Top level of the TDI knee count and radiance block.
// Depends on tkcr_pkg, tkcr_front, tkcr_queue, tkcr_back.
//
// Slave stream: one transfer per item, four 10-bit offsets and four 24-bit
// gains. Master stream: five transfers per item, knees 0 to 4, tlast on
// knee 4. Each knee carries its number, its averaged count in 1/64 count
// and its radiance in the gains' fixed-point format.
// The front end registers the products, sorts them combinationally and
// writes a four-entry queue; the back end issues one knee per cycle,
// while the receiver does not stall and the queue is not empty, into
// three pipelined dividers of 16 stages. The back end issues all five
// knees of an item before popping it; meanwhile the front end can take new items.
// Reset clears the queue, the knee counter and all valid flags.
// When the receiver stalls, the back pipeline holds; the front end keeps
// accepting until the queue fills, then drops s_tready.
module tdi_knee_count_radiance (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// offset_det0..3 (10b each), then gain_det0..3 (24b each)
	input  logic [135:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// knee_number (3b), knee_count (18b), knee_radiance (34b), one zero pad bit
	output logic [55:0]  m_tdata,
	output logic         m_tlast
);
	import tkcr_pkg::*;

	logic        q_full, q_wr, q_pop;
	tkcr_entry_t q_wdata, q_rdata;
	tkcr_qctl_t  q_ctl;

	tkcr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_wr     (q_wr),
		.q_wdata  (q_wdata)
	);

	tkcr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.full   (q_full),
		.ctl_o  (q_ctl),
		.pop    (q_pop),
		.rdata  (q_rdata)
	);

	tkcr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qctl     (q_ctl),
		.head     (q_rdata),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

@@ dv/tdi_knee_count_radiance_test.sv @@
// Testbench for tdi_knee_count_radiance: drives detector offsets and gains
// over the slave stream and checks the five knees of each item on the master stream.
// Depends on tkcr_pkg and the tdi_knee_count_radiance RTL.
module tdi_knee_count_radiance_test;
	import tkcr_pkg::*;

	typedef struct {
		logic [2:0]  knee;
		logic [17:0] cnt;
		logic [33:0] rad;
		logic        last;
	} knee_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [55:0]  m_tdata;
	logic         m_tlast;

	knee_t knee_q[$];
	int    errors;
	int    items_sent;
	int    knees_seen;
	int    cycles;
	bit    stall_on;

	tdi_knee_count_radiance DUT (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [63:0] quot_term(logic [63:0] r, logic [63:0] g);
		logic [63:0] q;
		if (g == 0)
			return 64'd65472;
		q = (r * 64) / g;
		if (q > 64'd65472)
			q = 64'd65472;
		return q;
	endfunction

	task automatic predict_knees(logic [9:0] off[4], logic [23:0] gn[4]);
		logic [63:0] sat[4];
		logic [63:0] rad[4];
		logic [63:0] sum;
		int          ord[4];
		int          t;
		knee_t       e;
		for (int i = 0; i < 4; i++) begin
			sat[i] = 1023 - off[i];
			rad[i] = sat[i] * gn[i];
			ord[i] = i;
		end
		for (int p = 0; p < 3; p++)
			for (int i = 0; i < 3 - p; i++)
				if (rad[ord[i]] > rad[ord[i+1]]) begin
					t = ord[i];
					ord[i] = ord[i+1];
					ord[i+1] = t;
				end
		e = '{knee: 0, cnt: 0, rad: 0, last: 0};
		knee_q.push_back(e);
		for (int k = 1; k < 5; k++) begin
			sum = 0;
			for (int m = 0; m < k; m++)
				sum += sat[ord[m]] * 64;
			for (int m = k; m < 4; m++)
				sum += quot_term(rad[ord[k-1]], gn[ord[m]]);
			e.knee = 3'(k);
			e.cnt  = sum[17:0];
			e.rad  = rad[ord[k-1]][33:0];
			e.last = (k == 4);
			knee_q.push_back(e);
		end
	endtask

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
	endfunction

	task automatic send_item(logic [9:0] off[4], logic [23:0] gn[4]);
		int g;
		g = stall_on ? gap_len() : 0;
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		predict_knees(off, gn);
		s_tvalid <= 1'b1;
		s_tdata  <= {gn[3], gn[2], gn[1], gn[0], off[3], off[2], off[1], off[0]};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	always @(posedge clk) begin
		knee_t e;
		if (arst_n && m_tvalid && m_tready) begin
			knees_seen++;
			if (knee_q.size() == 0) begin
				$error("unexpected knee transfer %h", m_tdata);
				errors++;
			end else begin
				e = knee_q.pop_front();
				if (m_tdata[2:0] !== e.knee) begin
					$error("knee_number exp %0d got %0d", e.knee, m_tdata[2:0]);
					errors++;
				end
				if (m_tdata[20:3] !== e.cnt) begin
					$error("knee_count exp %0d got %0d", e.cnt, m_tdata[20:3]);
					errors++;
				end
				if (m_tdata[54:21] !== e.rad) begin
					$error("knee_radiance exp %0d got %0d", e.rad, m_tdata[54:21]);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last_knee exp %0d got %0d", e.last, m_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!stall_on)
			m_tready <= 1'b1;
		else if ($urandom_range(0, 19) == 0)
			m_tready <= 1'b0;
		else if ($urandom_range(0, 2) != 0)
			m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic test_directed();
		logic [9:0]  off[4];
		logic [23:0] gn[4];
		off = '{0, 0, 0, 0};
		gn = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
		send_item(off, gn);
		off = '{1023, 1023, 1023, 1023};
		send_item(off, gn);
		gn = '{0, 0, 0, 0};
		off = '{0, 0, 0, 0};
		send_item(off, gn);
		off = '{0, 1023, 500, 7};
		gn = '{0, 24'h010000, 24'hFFFFFF, 24'h000001};
		send_item(off, gn);
		off = '{100, 100, 100, 100};
		gn = '{24'h123456, 24'h123456, 24'h123456, 24'h123456};
		send_item(off, gn);
		off = '{0, 511, 767, 895};
		gn = '{24'h000100, 24'h000200, 24'h000400, 24'h000800};
		send_item(off, gn);
		off = '{1023, 0, 1023, 0};
		gn = '{24'hFFFFFF, 0, 24'h000001, 24'hAAAAAA};
		send_item(off, gn);
		off = '{10'h155, 10'h2AA, 10'h155, 10'h2AA};
		gn = '{24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA};
		send_item(off, gn);
		off = '{3, 2, 1, 0};
		gn = '{24'h800000, 24'h400000, 24'h200000, 24'h100000};
		send_item(off, gn);
	endtask

	task automatic test_random(int n);
		logic [9:0]  off[4];
		logic [23:0] gn[4];
		for (int j = 0; j < n; j++) begin
			for (int i = 0; i < 4; i++) begin
				case ($urandom_range(0, 7))
					0: off[i] = 10'd1023;
					1: off[i] = 10'd0;
					default: off[i] = 10'($urandom_range(0, 1023));
				endcase
				case ($urandom_range(0, 7))
					0: gn[i] = 24'd0;
					1: gn[i] = 24'hFFFFFF;
					2: gn[i] = 24'($urandom_range(1, 255));
					default: gn[i] = 24'($urandom_range(0, 24'hFFFFFF));
				endcase
			end
			if ($urandom_range(0, 9) == 0) begin
				off[1] = off[0];
				gn[1] = gn[0];
			end
			send_item(off, gn);
		end
	endtask

	task automatic test_drain_pause();
		s_tvalid <= 1'b0;
		while (knee_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		errors = 0;
		items_sent = 0;
		knees_seen = 0;
		cycles = 0;
		stall_on = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		stall_on = 1'b1;
		test_random(160);
		test_drain_pause();
		stall_on = 1'b0;
		test_random(40);
		stall_on = 1'b1;
		test_random(160);
		s_tvalid <= 1'b0;
		while (knee_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		$display("Sent %0d items (extremes, zero gains, full offsets, ties, random)", items_sent);
		$display("Checked %0d knee transfers under random stalls on both streams", knees_seen);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

@@ tdi_knee_count_radiance.f @@
hdl/tkcr_pkg.sv
hdl/tkcr_front.sv
hdl/tkcr_queue.sv
hdl/tkcr_div_lane.sv
hdl/tkcr_back.sv
hdl/tdi_knee_count_radiance.sv
dv/tdi_knee_count_radiance_test.sv
